[hw/rtl/cjt_pkg.sv]
// cubic joint trajectory package: sizes, command and status types, fixed-point helpers
// used by the controller, the datapath and the top level
package cjt_pkg;

   localparam int JOINTS     = 2;
   localparam int MAX_JOINTS = 3;
   localparam int IDX_W      = 3;
   localparam int DATA_W     = 32;
   localparam int JIDX_W     = 2;
   localparam int COEF_W     = 48;
   localparam int NUM_W      = 98;
   localparam int QUO_W      = 82;
   localparam int DEN_W      = 64;
   localparam int DIV_STEPS  = 98;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [IDX_W-1:0]  REG_DURATION = 3'd6;
   localparam logic [DATA_W-1:0] DUR_RESET    = 32'h0001_0000;
   localparam logic [46:0]       COEF_CAP     = {47{1'b1}};
   localparam logic signed [69:0] SAT_HI      = 70'sd9223372036854775807;
   localparam logic signed [69:0] SAT_LO      = -70'sd9223372036854775807;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_T2,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_END,
      OP_MUL_LOAD,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_DONE,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      DIV_QUAD,
      DIV_CUB_T2,
      DIV_CUB_T
   } div_type;

   typedef enum logic [1:0] {
      MUL_M,
      MUL_VEL,
      MUL_P1,
      MUL_POS
   } mul_type;

   typedef struct packed {
      op_type              op;
      logic                capture;
      logic [JIDX_W-1:0]   joint;
      div_type             div;
      mul_type             mul;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic signed [69:0] sext70(input logic signed [63:0] x);
      return $signed({{6{x[63]}}, x});
   endfunction

   function automatic logic signed [63:0] sat63(input logic signed [69:0] x);
      if (x > SAT_HI) begin
         return SAT_HI[63:0];
      end else if (x < SAT_LO) begin
         return SAT_LO[63:0];
      end
      return x[63:0];
   endfunction

   function automatic logic [62:0] mag63(input logic signed [63:0] x);
      logic signed [63:0] n;
      n = -x;
      return x[63] ? n[62:0] : x[62:0];
   endfunction

   function automatic logic signed [63:0] apply_sign(input logic [62:0] m, input logic neg);
      logic signed [63:0] p;
      p = $signed({1'b0, m});
      return neg ? -p : p;
   endfunction

   function automatic logic signed [63:0] q32_to_q16(input logic signed [63:0] x);
      logic [62:0] m;
      m = mag63(x);
      return apply_sign({16'b0, m[62:16]}, x[63]);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

[hw/rtl/cjt_req_if.sv]
// request channel: valid/ready handshake carrying one sample time
// depends on nothing
interface cjt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink (input valid, input sample_time, output ready);
endinterface

[hw/rtl/cjt_rsp_if.sv]
// response channel: valid/ready handshake carrying one joint result
// depends on nothing
interface cjt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  joint_index;
   logic [31:0] position;
   logic [31:0] velocity;
   logic [31:0] acceleration;
   logic        last_joint;

   modport source (output valid, output joint_index, output position, output velocity,
                   output acceleration, output last_joint, input ready);
   modport sink (input valid, input joint_index, input position, input velocity,
                 input acceleration, input last_joint, output ready);
endinterface

[hw/rtl/cjt_ctrl.sv]
// cubic joint trajectory controller: sequences coefficient division and per-joint evaluation
// depends on cjt_pkg
module cjt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 cfg_hit,
   input  cjt_pkg::status_type  status,
   output cjt_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T2,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_END,
      ST_MUL_LOAD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_DONE,
      ST_OUT
   } state_type;

   localparam logic [cjt_pkg::JIDX_W-1:0] LAST_J = cjt_pkg::JIDX_W'(cjt_pkg::JOINTS - 1);
   localparam logic [cjt_pkg::STEP_W-1:0] LAST_S = cjt_pkg::STEP_W'(cjt_pkg::DIV_STEPS - 1);

   state_type                      state_ff;
   logic [cjt_pkg::JIDX_W-1:0]     joint_ff;
   cjt_pkg::div_type               div_ff;
   cjt_pkg::mul_type               mul_ff;
   logic [cjt_pkg::STEP_W-1:0]     step_ff;
   logic                           ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         joint_ff <= '0;
         div_ff   <= cjt_pkg::DIV_QUAD;
         mul_ff   <= cjt_pkg::MUL_M;
         step_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (cfg_hit) begin
            ready_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  joint_ff <= '0;
                  mul_ff   <= cjt_pkg::MUL_M;
                  state_ff <= ready_ff ? ST_MUL_LOAD : ST_T2;
               end
            end
            ST_T2: begin
               div_ff   <= cjt_pkg::DIV_QUAD;
               state_ff <= ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
               if (step_ff == LAST_S) begin
                  state_ff <= ST_DIV_END;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DIV_END: begin
               unique case (div_ff)
                  cjt_pkg::DIV_QUAD: begin
                     div_ff   <= cjt_pkg::DIV_CUB_T2;
                     state_ff <= ST_DIV_INIT;
                  end
                  cjt_pkg::DIV_CUB_T2: begin
                     div_ff   <= cjt_pkg::DIV_CUB_T;
                     state_ff <= ST_DIV_INIT;
                  end
                  default: begin
                     if (joint_ff == LAST_J) begin
                        ready_ff <= 1'b1;
                        joint_ff <= '0;
                        mul_ff   <= cjt_pkg::MUL_M;
                        state_ff <= ST_MUL_LOAD;
                     end else begin
                        joint_ff <= joint_ff + 1'b1;
                        div_ff   <= cjt_pkg::DIV_QUAD;
                        state_ff <= ST_DIV_INIT;
                     end
                  end
               endcase
            end
            ST_MUL_LOAD: state_ff <= ST_MUL_LO;
            ST_MUL_LO:   state_ff <= ST_MUL_HI;
            ST_MUL_HI:   state_ff <= ST_MUL_DONE;
            ST_MUL_DONE: begin
               if (mul_ff == cjt_pkg::MUL_POS) begin
                  state_ff <= ST_OUT;
               end else begin
                  mul_ff   <= cjt_pkg::mul_type'(mul_ff + 2'd1);
                  state_ff <= ST_MUL_LOAD;
               end
            end
            ST_OUT: begin
               if (status.out_free) begin
                  if (joint_ff == LAST_J) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     joint_ff <= joint_ff + 1'b1;
                     mul_ff   <= cjt_pkg::MUL_M;
                     state_ff <= ST_MUL_LOAD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.joint   = joint_ff;
      cmd.div     = div_ff;
      cmd.mul     = mul_ff;
      unique case (state_ff)
         ST_T2:       cmd.op = cjt_pkg::OP_T2;
         ST_DIV_INIT: cmd.op = cjt_pkg::OP_DIV_INIT;
         ST_DIV_STEP: cmd.op = cjt_pkg::OP_DIV_STEP;
         ST_DIV_END:  cmd.op = cjt_pkg::OP_DIV_END;
         ST_MUL_LOAD: cmd.op = cjt_pkg::OP_MUL_LOAD;
         ST_MUL_LO:   cmd.op = cjt_pkg::OP_MUL_LO;
         ST_MUL_HI:   cmd.op = cjt_pkg::OP_MUL_HI;
         ST_MUL_DONE: cmd.op = cjt_pkg::OP_MUL_DONE;
         ST_OUT:      cmd.op = status.out_free ? cjt_pkg::OP_OUT : cjt_pkg::OP_NONE;
         default:     cmd.op = cjt_pkg::OP_NONE;
      endcase
   end

endmodule

[hw/rtl/cjt_dpath.sv]
// cubic joint trajectory datapath: registers, bit-serial divider, shared 32x32 multiplier,
// coefficient stores and the response register; depends on cjt_pkg
module cjt_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  cjt_pkg::cmd_type              cmd,
   output cjt_pkg::status_type           status,
   input  logic [31:0]                   req_sample_time,
   input  logic                          csr_wr_en,
   input  logic [cjt_pkg::IDX_W-1:0]     csr_index,
   input  logic [cjt_pkg::DATA_W-1:0]    csr_wr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_joint_index,
   output logic [31:0]                   rsp_position,
   output logic [31:0]                   rsp_velocity,
   output logic [31:0]                   rsp_acceleration,
   output logic                          rsp_last_joint
);

   logic [31:0] start_ff [cjt_pkg::MAX_JOINTS];
   logic [31:0] end_ff   [cjt_pkg::MAX_JOINTS];
   logic [31:0] dur_ff;

   logic signed [cjt_pkg::COEF_W-1:0] quad_ff  [cjt_pkg::MAX_JOINTS];
   logic signed [cjt_pkg::COEF_W-1:0] cubic_ff [cjt_pkg::MAX_JOINTS];

   logic [31:0]                  t_ff;
   logic [63:0]                  t2_ff;
   logic [cjt_pkg::NUM_W-1:0]    num_ff;
   logic [cjt_pkg::DEN_W-1:0]    den_ff;
   logic [63:0]                  rem_ff;
   logic [cjt_pkg::QUO_W-1:0]    quo_ff;
   logic                         ovf_ff;

   logic [62:0]                  x_mag_ff;
   logic                         x_neg_ff;
   logic [63:0]                  lp_ff;
   logic [62:0]                  hp_ff;
   logic signed [63:0]           m_ff;
   logic signed [63:0]           vel_ff;
   logic signed [63:0]           p1_ff;
   logic signed [63:0]           posq_ff;

   logic                         rsp_valid_ff;
   logic [1:0]                   rsp_joint_ff;
   logic [31:0]                  rsp_pos_ff;
   logic [31:0]                  rsp_vel_ff;
   logic [31:0]                  rsp_acc_ff;
   logic                         rsp_last_ff;

   logic [31:0]                  tf;
   logic signed [32:0]           delta;
   logic                         dneg;
   logic [32:0]                  dmag;
   logic [34:0]                  three_d;
   logic [33:0]                  two_d;
   logic [64:0]                  rem_sh;
   logic                         ge;
   logic [64:0]                  rem_sub;
   logic [46:0]                  capped;
   logic signed [47:0]           cap_pos;
   logic [31:0]                  mul_a;
   logic [63:0]                  mul_p;
   logic [94:0]                  full;
   logic [62:0]                  r_mag;
   logic signed [63:0]           r_signed;
   logic signed [69:0]           m70;
   logic signed [69:0]           a2_70;
   logic signed [63:0]           a2;
   logic signed [63:0]           c3;
   logic signed [63:0]           vin;
   logic signed [63:0]           pin;
   logic signed [63:0]           acc;
   logic signed [63:0]           src;
   logic signed [63:0]           pos_sum;

   assign tf = (dur_ff == '0) ? 32'd1 : dur_ff;

   always_comb begin
      delta   = $signed({end_ff[cmd.joint][31], end_ff[cmd.joint]})
              - $signed({start_ff[cmd.joint][31], start_ff[cmd.joint]});
      dneg    = delta[32];
      dmag    = dneg ? 33'(-delta) : 33'(delta);
      three_d = 35'(dmag) + {1'b0, dmag, 1'b0};
      two_d   = {dmag, 1'b0};
      rem_sh  = {rem_ff, num_ff[cjt_pkg::NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      capped  = (ovf_ff || (quo_ff > cjt_pkg::QUO_W'(cjt_pkg::COEF_CAP)))
              ? cjt_pkg::COEF_CAP : quo_ff[46:0];
      cap_pos = $signed({1'b0, capped});
   end

   always_comb begin
      a2    = 64'(quad_ff[cmd.joint]);
      c3    = 64'(cubic_ff[cmd.joint]);
      m70   = cjt_pkg::sext70(m_ff);
      a2_70 = cjt_pkg::sext70(a2);
      vin   = cjt_pkg::sat63(cjt_pkg::sext70(cjt_pkg::sat63(m70 + (m70 <<< 1)))
                             + (a2_70 <<< 1));
      pin   = cjt_pkg::sat63(m70 + a2_70);
      acc   = cjt_pkg::sat63(cjt_pkg::sext70(cjt_pkg::sat63((m70 <<< 2) + (m70 <<< 1)))
                             + (a2_70 <<< 1));
      case (cmd.mul)
         cjt_pkg::MUL_M:   src = c3;
         cjt_pkg::MUL_VEL: src = vin;
         cjt_pkg::MUL_P1:  src = pin;
         default:          src = p1_ff;
      endcase
      pos_sum = cjt_pkg::q32_to_q16(posq_ff) + 64'(signed'(start_ff[cmd.joint]));
   end

   always_comb begin
      case (cmd.op)
         cjt_pkg::OP_T2:     mul_a = tf;
         cjt_pkg::OP_MUL_HI: mul_a = {1'b0, x_mag_ff[62:32]};
         default:            mul_a = x_mag_ff[31:0];
      endcase
      mul_p    = mul_a * ((cmd.op == cjt_pkg::OP_T2) ? tf : t_ff);
      full     = {hp_ff, 32'b0} + {31'b0, lp_ff};
      r_mag    = (full[94:16] > {16'b0, {63{1'b1}}}) ? {63{1'b1}} : full[78:16];
      r_signed = cjt_pkg::apply_sign(r_mag, x_neg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cjt_pkg::MAX_JOINTS; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
         end
         dur_ff <= cjt_pkg::DUR_RESET;
      end else if (csr_wr_en) begin
         if (csr_index < cjt_pkg::REG_DURATION) begin
            if (csr_index[0]) begin
               end_ff[csr_index[2:1]] <= csr_wr_data;
            end else begin
               start_ff[csr_index[2:1]] <= csr_wr_data;
            end
         end else if (csr_index == cjt_pkg::REG_DURATION) begin
            dur_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff <= (req_sample_time > tf) ? tf : req_sample_time;
      end
      case (cmd.op)
         cjt_pkg::OP_T2: t2_ff <= mul_p;
         cjt_pkg::OP_DIV_INIT: begin
            rem_ff <= '0;
            quo_ff <= '0;
            ovf_ff <= 1'b0;
            case (cmd.div)
               cjt_pkg::DIV_QUAD: begin
                  num_ff <= cjt_pkg::NUM_W'({three_d, 48'b0});
                  den_ff <= t2_ff;
               end
               cjt_pkg::DIV_CUB_T2: begin
                  num_ff <= cjt_pkg::NUM_W'({two_d, 48'b0});
                  den_ff <= t2_ff;
               end
               default: begin
                  num_ff <= {quo_ff, 16'b0};
                  den_ff <= cjt_pkg::DEN_W'(tf);
               end
            endcase
         end
         cjt_pkg::OP_DIV_STEP: begin
            num_ff <= {num_ff[cjt_pkg::NUM_W-2:0], 1'b0};
            rem_ff <= ge ? rem_sub[63:0] : rem_sh[63:0];
            quo_ff <= {quo_ff[cjt_pkg::QUO_W-2:0], ge};
            ovf_ff <= ovf_ff | quo_ff[cjt_pkg::QUO_W-1];
         end
         cjt_pkg::OP_DIV_END: begin
            if (cmd.div == cjt_pkg::DIV_QUAD) begin
               quad_ff[cmd.joint] <= dneg ? -cap_pos : cap_pos;
            end else if (cmd.div == cjt_pkg::DIV_CUB_T) begin
               cubic_ff[cmd.joint] <= dneg ? cap_pos : -cap_pos;
            end
         end
         cjt_pkg::OP_MUL_LOAD: begin
            x_mag_ff <= cjt_pkg::mag63(src);
            x_neg_ff <= src[63];
         end
         cjt_pkg::OP_MUL_LO: lp_ff <= mul_p;
         cjt_pkg::OP_MUL_HI: hp_ff <= mul_p[62:0];
         cjt_pkg::OP_MUL_DONE: begin
            case (cmd.mul)
               cjt_pkg::MUL_M:   m_ff    <= r_signed;
               cjt_pkg::MUL_VEL: vel_ff  <= r_signed;
               cjt_pkg::MUL_P1:  p1_ff   <= r_signed;
               default:          posq_ff <= r_signed;
            endcase
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == cjt_pkg::OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == cjt_pkg::OP_OUT) begin
         rsp_joint_ff <= cmd.joint;
         rsp_pos_ff   <= cjt_pkg::sat32(pos_sum);
         rsp_vel_ff   <= cjt_pkg::sat32(cjt_pkg::q32_to_q16(vel_ff));
         rsp_acc_ff   <= cjt_pkg::sat32(cjt_pkg::q32_to_q16(acc));
         rsp_last_ff  <= (cmd.joint == cjt_pkg::JIDX_W'(cjt_pkg::JOINTS - 1));
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_joint_index   = rsp_joint_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_velocity      = rsp_vel_ff;
   assign rsp_acceleration  = rsp_acc_ff;
   assign rsp_last_joint    = rsp_last_ff;

endmodule

[hw/rtl/cubic_joint_trajectory_core.sv]
// Rest-to-rest cubic trajectory generator, Q16.16, one response per joint for each sample
// request. The first request after reset or after a write to a start, end or duration
// register first derives the joint coefficients on a one-bit-per-cycle divider (three
// 98-step divisions per joint). Each joint then takes four saturating products with the
// sample time on one shared 32x32 multiplier, each split into load, low partial product,
// high partial product and result steps, then loads the response register once it is
// free. A new request is taken once the last response has entered the output register.
// depends on cjt_pkg, cjt_req_if, cjt_rsp_if, cjt_ctrl, cjt_dpath
module cubic_joint_trajectory_core (
   input  logic                          clock,
   input  logic                          reset,
   cjt_req_if.sink                       req,
   cjt_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [cjt_pkg::IDX_W-1:0]     csr_index,
   input  logic [cjt_pkg::DATA_W-1:0]    csr_wr_data
);

   cjt_pkg::cmd_type    cmd;
   cjt_pkg::status_type status;
   logic                cfg_hit;

   assign cfg_hit = csr_wr_en && (csr_index <= cjt_pkg::REG_DURATION);

   cjt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cfg_hit   (cfg_hit),
      .status    (status),
      .cmd       (cmd)
   );

   cjt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_time  (req.sample_time),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_joint_index  (rsp.joint_index),
      .rsp_position     (rsp.position),
      .rsp_velocity     (rsp.velocity),
      .rsp_acceleration (rsp.acceleration),
      .rsp_last_joint   (rsp.last_joint)
   );

endmodule

[bench/testbench.sv]
// self-checking bench for cubic_joint_trajectory_core: random sample-time requests
// under several register settings, results checked against an in-bench fixed-point predictor
// depends on cjt_pkg, cjt_req_if, cjt_rsp_if and the core
`timescale 1ns / 1ps

module testbench;

   typedef enum logic [2:0] {
      R_START_J0, R_END_J0, R_START_J1, R_END_J1,
      R_START_J2, R_END_J2, R_DURATION, R_SPARE
   } reg_index_type;

   typedef struct {
      logic [1:0]  joint;
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] acc;
      logic        last;
   } joint_state_type;

   localparam logic signed [63:0] Q32_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic [127:0]       COEF_MAX = (128'd1 << 47) - 1;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [cjt_pkg::IDX_W-1:0] csr_index;
   logic [cjt_pkg::DATA_W-1:0] csr_wr_data;

   cjt_req_if req_ch();
   cjt_rsp_if rsp_ch();

   cubic_joint_trajectory_core i_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   logic signed [31:0] start_q[cjt_pkg::MAX_JOINTS];
   logic signed [31:0] end_q[cjt_pkg::MAX_JOINTS];
   logic [31:0]        dur_q;
   logic               coefs_valid;
   logic signed [63:0] quad_q[cjt_pkg::MAX_JOINTS];
   logic signed [63:0] cubic_q[cjt_pkg::MAX_JOINTS];

   logic [31:0]     sample_queue[$];
   joint_state_type joint_queue[$];
   int          errors = 0;
   int          sent = 0;
   int          received = 0;
   int          settings = 0;
   logic        calm = 0;
   int          gap = 0;
   int          stall = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [69:0] s;
      s = 70'(a) + 70'(b);
      if (s > 70'(Q32_MAX)) return Q32_MAX;
      if (s < -70'(Q32_MAX)) return -Q32_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_times(logic signed [63:0] x, int k);
      logic signed [63:0] r;
      r = 0;
      for (int i = 0; i < k; i++) r = sat_sum(r, x);
      return r;
   endfunction

   function automatic logic signed [63:0] times_t(logic signed [63:0] x, logic [31:0] t);
      logic [127:0] p;
      logic [63:0]  m;
      m = x < 0 ? 64'(-x) : 64'(x);
      p = (128'(m) * 128'(t)) >> 16;
      if (p > 128'(Q32_MAX)) p = 128'(Q32_MAX);
      return x < 0 ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   function automatic logic signed [63:0] to_q16(logic signed [63:0] x);
      logic [63:0] m;
      m = x < 0 ? 64'(-x) : 64'(x);
      m = m >> 16;
      return x < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [31:0] clip32(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   task automatic derive_coefs();
      logic [127:0] t, t2, mag, q;
      logic signed [63:0] d;
      t = dur_q == 0 ? 128'd1 : 128'(dur_q);
      t2 = t * t;
      for (int j = 0; j < cjt_pkg::MAX_JOINTS; j++) begin
         d = 64'(end_q[j]) - 64'(start_q[j]);
         mag = d < 0 ? 128'(-d) : 128'(d);
         q = ((3 * mag) << 48) / t2;
         if (q > COEF_MAX) q = COEF_MAX;
         quad_q[j] = d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
         q = ((2 * mag) << 48) / t2;
         q = (q << 16) / t;
         if (q > COEF_MAX) q = COEF_MAX;
         cubic_q[j] = d < 0 ? $signed(q[63:0]) : -$signed(q[63:0]);
      end
      coefs_valid = 1;
   endtask

   task automatic predict_joints(logic [31:0] t_in);
      logic [31:0] t, tf;
      logic signed [63:0] m, two_a2, acc, vel, pos;
      joint_state_type e;
      if (!coefs_valid) derive_coefs();
      tf = dur_q == 0 ? 32'd1 : dur_q;
      t = t_in > tf ? tf : t_in;
      for (int j = 0; j < cjt_pkg::JOINTS; j++) begin
         m = times_t(cubic_q[j], t);
         two_a2 = sat_times(quad_q[j], 2);
         acc = sat_sum(sat_times(m, 6), two_a2);
         vel = times_t(sat_sum(sat_times(m, 3), two_a2), t);
         pos = times_t(times_t(sat_sum(m, quad_q[j]), t), t);
         pos = sat_sum(to_q16(pos), 64'(start_q[j]));
         e.joint = j[1:0];
         e.pos = clip32(pos);
         e.vel = clip32(to_q16(vel));
         e.acc = clip32(to_q16(acc));
         e.last = (j == cjt_pkg::JOINTS - 1);
         joint_queue.push_back(e);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
         req_ch.sample_time <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_joints(req_ch.sample_time);
            sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap > 0) begin
               gap--;
               req_ch.valid <= 0;
            end else if (sample_queue.size() > 0) begin
               req_ch.valid <= 1;
               req_ch.sample_time <= sample_queue.pop_front();
               if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      joint_state_type e;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            received++;
            if (joint_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response joint %0d", rsp_ch.joint_index);
            end else begin
               e = joint_queue.pop_front();
               if (rsp_ch.joint_index !== e.joint || rsp_ch.position !== e.pos ||
                   rsp_ch.velocity !== e.vel || rsp_ch.acceleration !== e.acc ||
                   rsp_ch.last_joint !== e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp j%0d p%h v%h a%h l%b got j%0d p%h v%h a%h l%b",
                              e.joint, e.pos, e.vel, e.acc, e.last, rsp_ch.joint_index,
                              rsp_ch.position, rsp_ch.velocity, rsp_ch.acceleration,
                              rsp_ch.last_joint);
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
            if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 14);
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      if (idx == R_DURATION) begin
         dur_q = val;
         coefs_valid = 0;
      end else if (idx != R_SPARE) begin
         if (idx[0]) end_q[idx >> 1] = val;
         else start_q[idx >> 1] = val;
         coefs_valid = 0;
      end
   endtask

   // sampled away from the rising edge so driver updates are settled
   task automatic wait_idle();
      @(negedge clock);
      while (sample_queue.size() > 0 || req_ch.valid || joint_queue.size() > 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_pos();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
   endfunction

   function automatic logic [31:0] pick_time(logic [31:0] d);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return d;
         2: return $urandom;
         3: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, d);
      endcase
   endfunction

   initial begin
      logic [31:0] d;
      for (int j = 0; j < cjt_pkg::MAX_JOINTS; j++) begin
         start_q[j] = 0;
         end_q[j] = 0;
      end
      dur_q = cjt_pkg::DUR_RESET;
      coefs_valid = 0;
      csr_wr_en = 0;
      csr_index = 0;
      csr_wr_data = 0;
      req_ch.valid = 0;
      req_ch.sample_time = 0;
      rsp_ch.ready = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;

      // defaults after reset
      settings++;
      sample_queue = '{0, 1, 32'h8000, cjt_pkg::DUR_RESET - 1, cjt_pkg::DUR_RESET,
                       cjt_pkg::DUR_RESET + 1, 32'h8000_0000, 32'hFFFF_FFFF};
      wait_idle();

      // full-scale deltas of opposite sign, shortest duration
      write_reg(R_START_J0, 32'h8000_0000);
      write_reg(R_END_J0, 32'h7FFF_FFFF);
      write_reg(R_START_J1, 32'h7FFF_FFFF);
      write_reg(R_END_J1, 32'h8000_0000);
      write_reg(R_DURATION, 1);
      settings++;
      sample_queue = '{0, 1, 2, 32'h1_0000, 32'hFFFF_FFFF};
      wait_idle();

      // longest duration
      write_reg(R_DURATION, 32'hFFFF_FFFF);
      settings++;
      sample_queue = '{0, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      wait_idle();

      // zero duration, unused joint and spare index
      write_reg(R_START_J2, 32'h1234_5678);
      write_reg(R_END_J2, 32'h8765_4321);
      write_reg(R_SPARE, 32'hDEAD_BEEF);
      write_reg(R_DURATION, 0);
      settings++;
      sample_queue = '{0, 1, 2, 32'h5555_5555, 32'hAAAA_AAAA};
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         calm = (p == 9);
         for (int r = 0; r < 6; r++)
            if ($urandom_range(0, 1) == 0) write_reg(reg_index_type'(r), pick_pos());
         case ($urandom_range(0, 4))
            0: d = $urandom_range(1, 16);
            1: d = $urandom;
            default: d = $urandom_range(32'h4000, 32'h80000);
         endcase
         write_reg(R_DURATION, d);
         settings++;
         for (int i = 0; i < 24; i++) sample_queue.push_back(pick_time(d));
         wait_idle();
      end

      $display("covered %0d sample requests and %0d joint results over %0d register settings",
               sent, received, settings);
      if (errors == 0 && joint_queue.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
